@@ rtl/core/pnc_pkg.sv @@
// Shared types, constants and helpers for the palette nearest color finder.
// No dependencies; used by every module of the block.
`default_nettype none

package pnc_pkg;

  // Field widths
  localparam int unsigned COMP_W = 6;   // one DAC component
  localparam int unsigned SQ_W   = 12;  // square of a component difference
  localparam int unsigned SUM_W  = 8;   // sum of three components, max 189
  localparam int unsigned DIST_W = 14;  // squared distance, max 11907
  localparam int unsigned IDX_W  = 8;   // reported palette index
  localparam int unsigned CFG_IDX_W = 3;

  // Start values of the running bests at the head of every scan
  localparam logic [IDX_W-1:0]  BRIGHT_START_IDX = 8'd15;
  localparam logic [SUM_W-1:0]  BRIGHT_START_SUM = 8'd0;
  localparam logic [IDX_W-1:0]  DARK_START_IDX   = 8'd0;
  localparam logic [SUM_W-1:0]  DARK_START_SUM   = 8'd189;
  localparam logic [IDX_W-1:0]  MATCH_START_IDX  = 8'd0;
  localparam logic [DIST_W-1:0] DIST_START       = 14'd11907;

  // Target color reset values
  localparam logic [COMP_W-1:0] T1_RED_RST   = 6'd21;
  localparam logic [COMP_W-1:0] T1_GREEN_RST = 6'd21;
  localparam logic [COMP_W-1:0] T1_BLUE_RST  = 6'd63;
  localparam logic [COMP_W-1:0] T2_RED_RST   = 6'd42;
  localparam logic [COMP_W-1:0] T2_GREEN_RST = 6'd42;
  localparam logic [COMP_W-1:0] T2_BLUE_RST  = 6'd42;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T1_RED   = 3'd0,
    REG_T1_GREEN = 3'd1,
    REG_T1_BLUE  = 3'd2,
    REG_T2_RED   = 3'd3,
    REG_T2_GREEN = 3'd4,
    REG_T2_BLUE  = 3'd5
  } cfg_reg_e;

  // The four indices reported at the end of a scan
  typedef struct packed {
    logic [IDX_W-1:0] bright;
    logic [IDX_W-1:0] dark;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
  } scan_res_t;

  // One target color
  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } color_t;

  // Square of the absolute difference of two components
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                              input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pnc_dist.sv @@
// Squared RGB distance from one palette entry to one target color.
// Depends on pnc_pkg.
`default_nettype none

module pnc_dist
  import pnc_pkg::*;
(
  input  color_t              entry_i,
  input  color_t              target_i,
  output logic [DIST_W-1:0]   dist_o
);

  logic [SQ_W-1:0] sq_red, sq_green, sq_blue;

  // three small squares, then one add tree
  assign sq_red   = sq_diff(entry_i.red,   target_i.red);
  assign sq_green = sq_diff(entry_i.green, target_i.green);
  assign sq_blue  = sq_diff(entry_i.blue,  target_i.blue);

  assign dist_o = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);

endmodule

`default_nettype wire

@@ rtl/core/pnc_scan.sv @@
// Entry counter and the four running bests of one palette scan.
// Depends on pnc_pkg.
`default_nettype none

module pnc_scan
  import pnc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,    // take the current entry
  input  logic              final_i,   // current entry closes the scan
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [DIST_W-1:0] dist1_i,
  input  logic [DIST_W-1:0] dist2_i,
  output scan_res_t         res_o      // bests including the current entry
);

  localparam int unsigned CNT_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_ENTRIES - 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  bright_idx_q, bright_idx_d, dark_idx_q, dark_idx_d;
  logic [SUM_W-1:0]  bright_sum_q, bright_sum_d, dark_sum_q, dark_sum_d;
  logic [IDX_W-1:0]  first_idx_q, first_idx_d, second_idx_q, second_idx_d;
  logic [DIST_W-1:0] first_dist_q, first_dist_d, second_dist_q, second_dist_d;

  assign cur_idx = IDX_W'(cnt_q);

  // strict compares: the earlier entry keeps a tie
  always_comb begin
    bright_idx_d  = bright_idx_q;
    bright_sum_d  = bright_sum_q;
    dark_idx_d    = dark_idx_q;
    dark_sum_d    = dark_sum_q;
    first_idx_d   = first_idx_q;
    first_dist_d  = first_dist_q;
    second_idx_d  = second_idx_q;
    second_dist_d = second_dist_q;
    if (sum_i > bright_sum_q) begin
      bright_idx_d = cur_idx;
      bright_sum_d = sum_i;
    end
    if (sum_i < dark_sum_q) begin
      dark_idx_d = cur_idx;
      dark_sum_d = sum_i;
    end
    if (dist1_i < first_dist_q) begin
      first_idx_d  = cur_idx;
      first_dist_d = dist1_i;
    end
    if (dist2_i < second_dist_q) begin
      second_idx_d  = cur_idx;
      second_dist_d = dist2_i;
    end
  end

  assign res_o = '{bright: bright_idx_d, dark: dark_idx_d,
                   first: first_idx_d, second: second_idx_d};

  // counter wraps after the last palette slot
  assign cnt_d = (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);

  // running state; a final entry restarts the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      bright_idx_q  <= BRIGHT_START_IDX;
      bright_sum_q  <= BRIGHT_START_SUM;
      dark_idx_q    <= DARK_START_IDX;
      dark_sum_q    <= DARK_START_SUM;
      first_idx_q   <= MATCH_START_IDX;
      first_dist_q  <= DIST_START;
      second_idx_q  <= MATCH_START_IDX;
      second_dist_q <= DIST_START;
    end else if (step_i) begin
      if (final_i) begin
        cnt_q         <= '0;
        bright_idx_q  <= BRIGHT_START_IDX;
        bright_sum_q  <= BRIGHT_START_SUM;
        dark_idx_q    <= DARK_START_IDX;
        dark_sum_q    <= DARK_START_SUM;
        first_idx_q   <= MATCH_START_IDX;
        first_dist_q  <= DIST_START;
        second_idx_q  <= MATCH_START_IDX;
        second_dist_q <= DIST_START;
      end else begin
        cnt_q         <= cnt_d;
        bright_idx_q  <= bright_idx_d;
        bright_sum_q  <= bright_sum_d;
        dark_idx_q    <= dark_idx_d;
        dark_sum_q    <= dark_sum_d;
        first_idx_q   <= first_idx_d;
        first_dist_q  <= first_dist_d;
        second_idx_q  <= second_idx_d;
        second_dist_q <= second_dist_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/palette_nearest_color_finder.sv @@
// Top level of the palette nearest color finder: input register, target
// registers, distance units, scan tracker and result register.
// Depends on pnc_pkg, pnc_dist and pnc_scan.
`default_nettype none

// Palette entries stream in one per cycle; each is numbered by a counter that
// wraps after PALETTE_ENTRIES slots and starts at 0 on every scan. The block
// tracks the brightest and darkest entry and the entries nearest two target
// colors, first entry winning a tie, and on the entry flagged final_entry
// delivers one word with the four indices and starts a new scan. One entry is
// taken every cycle unless the input stalls; the limit is the compare and
// update of the running bests. A final entry's result passes the input
// register and the result register, waiting in the input register while the
// previous result still waits to be taken; only then does the input stall.
// Target colors are to be written through the cfg port only while no scan is
// in flight; the block itself does not enforce this.

module palette_nearest_color_finder
  import pnc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COMP_W-1:0]    cfg_data_i,
  // palette entries
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [COMP_W-1:0]    entry_red_i,
  input  logic [COMP_W-1:0]    entry_green_i,
  input  logic [COMP_W-1:0]    entry_blue_i,
  input  logic                 final_entry_i,
  // scan results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_W-1:0]     brightest_index_o,
  output logic [IDX_W-1:0]     darkest_index_o,
  output logic [IDX_W-1:0]     first_match_index_o,
  output logic [IDX_W-1:0]     second_match_index_o
);

  color_t            target1_q, target2_q;
  color_t            entry_q;
  logic              s1_valid_q;
  logic              s1_final_q;
  logic              step;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] dist1, dist2;
  scan_res_t         scan_res;
  scan_res_t         res_q;
  logic              out_valid_q;

  // target color registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target1_q <= '{red: T1_RED_RST, green: T1_GREEN_RST, blue: T1_BLUE_RST};
      target2_q <= '{red: T2_RED_RST, green: T2_GREEN_RST, blue: T2_BLUE_RST};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_T1_RED:   target1_q.red   <= cfg_data_i;
        REG_T1_GREEN: target1_q.green <= cfg_data_i;
        REG_T1_BLUE:  target1_q.blue  <= cfg_data_i;
        REG_T2_RED:   target2_q.red   <= cfg_data_i;
        REG_T2_GREEN: target2_q.green <= cfg_data_i;
        REG_T2_BLUE:  target2_q.blue  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the held entry moves on unless it closes a scan and the result slot is busy
  assign step       = s1_valid_q && (!s1_final_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      entry_q    <= '{red: entry_red_i, green: entry_green_i, blue: entry_blue_i};
      s1_final_q <= final_entry_i;
    end
  end

  // metrics of the held entry
  assign sum = SUM_W'(entry_q.red) + SUM_W'(entry_q.green) + SUM_W'(entry_q.blue);

  pnc_dist u_dist1 (
    .entry_i  (entry_q),
    .target_i (target1_q),
    .dist_o   (dist1)
  );

  pnc_dist u_dist2 (
    .entry_i  (entry_q),
    .target_i (target2_q),
    .dist_o   (dist2)
  );

  pnc_scan #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .final_i (s1_final_q),
    .sum_i   (sum),
    .dist1_i (dist1),
    .dist2_i (dist2),
    .res_o   (scan_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && s1_final_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_final_q) begin
      res_q <= scan_res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign brightest_index_o    = res_q.bright;
  assign darkest_index_o      = res_q.dark;
  assign first_match_index_o  = res_q.first;
  assign second_match_index_o = res_q.second;

  // a closing entry never passes a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_final_q && out_valid_q && !out_ready_i |-> !step && !in_ready_o)
    else $error("closing entry advanced over a pending result");

  // a new result appears only after a closing entry was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && s1_final_q))
    else $error("result raised without a closing entry");

  // a pending result that is not taken is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("pending result lost or changed");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for palette_nearest_color_finder: directed and random
// palette scans, checked word by word against an in-bench predictor.
// Depends on pnc_pkg and the RTL of the block; reads and writes no files.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnc_pkg::*;

  localparam int unsigned PALETTE_ENTRIES = 256;

  // Register slots past the last target register; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  // Predicts the four indices of every scan and checks the result words
  class scan_tracker;
    color_t           first_target, second_target;
    int unsigned      slot;
    logic [IDX_W-1:0] bright_idx, dark_idx, first_idx, second_idx;
    logic [SUM_W-1:0] bright_sum, dark_sum;
    logic [DIST_W-1:0] first_dist, second_dist;
    scan_res_t        expected_scans[$];
    int               mismatches, entries_seen, scans_checked;

    function new();
      first_target  = '{T1_RED_RST, T1_GREEN_RST, T1_BLUE_RST};
      second_target = '{T2_RED_RST, T2_GREEN_RST, T2_BLUE_RST};
      mismatches    = 0;
      entries_seen  = 0;
      scans_checked = 0;
      start_scan();
    endfunction

    function void start_scan();
      slot        = 0;
      bright_idx  = BRIGHT_START_IDX;
      bright_sum  = BRIGHT_START_SUM;
      dark_idx    = DARK_START_IDX;
      dark_sum    = DARK_START_SUM;
      first_idx   = MATCH_START_IDX;
      first_dist  = DIST_START;
      second_idx  = MATCH_START_IDX;
      second_dist = DIST_START;
    endfunction

    function void set_target(logic [CFG_IDX_W-1:0] idx, logic [COMP_W-1:0] val);
      case (idx)
        REG_T1_RED:   first_target.red    = val;
        REG_T1_GREEN: first_target.green  = val;
        REG_T1_BLUE:  first_target.blue   = val;
        REG_T2_RED:   second_target.red   = val;
        REG_T2_GREEN: second_target.green = val;
        REG_T2_BLUE:  second_target.blue  = val;
        default: ;
      endcase
    endfunction

    function int comp_sq(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
    endfunction

    function int color_dist(color_t e, color_t t);
      return comp_sq(e.red, t.red) + comp_sq(e.green, t.green) + comp_sq(e.blue, t.blue);
    endfunction

    // Fold one accepted entry into the running bests; a final entry closes the scan
    function void note_entry(color_t e, logic last);
      int sum, d1, d2;
      scan_res_t word;
      sum = int'(e.red) + int'(e.green) + int'(e.blue);
      d1  = color_dist(e, first_target);
      d2  = color_dist(e, second_target);
      // strict compares: the earliest entry keeps a tie
      if (sum > bright_sum) begin
        bright_idx = IDX_W'(slot);
        bright_sum = SUM_W'(sum);
      end
      if (sum < dark_sum) begin
        dark_idx = IDX_W'(slot);
        dark_sum = SUM_W'(sum);
      end
      if (d1 < first_dist) begin
        first_idx  = IDX_W'(slot);
        first_dist = DIST_W'(d1);
      end
      if (d2 < second_dist) begin
        second_idx  = IDX_W'(slot);
        second_dist = DIST_W'(d2);
      end
      slot = (slot >= PALETTE_ENTRIES - 1) ? 0 : slot + 1;
      entries_seen++;
      if (last) begin
        word.bright = bright_idx;
        word.dark   = dark_idx;
        word.first  = first_idx;
        word.second = second_idx;
        expected_scans.push_back(word);
        start_scan();
      end
    endfunction

    function void check_scan(scan_res_t got);
      scan_res_t want;
      if (expected_scans.size() == 0) begin
        $display("%0t: unexpected result word %h, no scan pending", $time, got);
        mismatches++;
        return;
      end
      want = expected_scans.pop_front();
      scans_checked++;
      if (got.bright !== want.bright) begin
        $display("%0t: brightest_index expected %0d got %0d", $time, want.bright, got.bright);
        mismatches++;
      end
      if (got.dark !== want.dark) begin
        $display("%0t: darkest_index expected %0d got %0d", $time, want.dark, got.dark);
        mismatches++;
      end
      if (got.first !== want.first) begin
        $display("%0t: first_match_index expected %0d got %0d", $time, want.first, got.first);
        mismatches++;
      end
      if (got.second !== want.second) begin
        $display("%0t: second_match_index expected %0d got %0d", $time, want.second,
                 got.second);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [COMP_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [COMP_W-1:0]    entry_red_i = '0;
  logic [COMP_W-1:0]    entry_green_i = '0;
  logic [COMP_W-1:0]    entry_blue_i = '0;
  logic                 final_entry_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [IDX_W-1:0]     brightest_index_o;
  logic [IDX_W-1:0]     darkest_index_o;
  logic [IDX_W-1:0]     first_match_index_o;
  logic [IDX_W-1:0]     second_match_index_o;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  scan_res_t   got_word;
  scan_tracker sb = new();

  palette_nearest_color_finder #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .entry_red_i         (entry_red_i),
    .entry_green_i       (entry_green_i),
    .entry_blue_i        (entry_blue_i),
    .final_entry_i       (final_entry_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .brightest_index_o   (brightest_index_o),
    .darkest_index_o     (darkest_index_o),
    .first_match_index_o (first_match_index_o),
    .second_match_index_o(second_match_index_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random back-pressure per the current stall rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Check every result word taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word.bright = brightest_index_o;
      got_word.dark   = darkest_index_o;
      got_word.first  = first_match_index_o;
      got_word.second = second_match_index_o;
      sb.check_scan(got_word);
    end
  end

  // Component with extra weight on the two extremes
  function automatic logic [COMP_W-1:0] pick_component();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COMP_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Send one palette entry; entered and left at a falling edge
  task automatic push_entry(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                            input logic [COMP_W-1:0] b, input logic last);
    color_t word;
    word.red   = r;
    word.green = g;
    word.blue  = b;
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    entry_red_i   <= r;
    entry_green_i <= g;
    entry_blue_i  <= b;
    final_entry_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_entry(word, last);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every pending scan result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.expected_scans.size() != 0);
  endtask

  // Caller lowers cfg_we_i after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COMP_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_target(idx, val);
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    int len, phase_items, long_scans, settings;
    logic [COMP_W-1:0] r, g, b;
    long_scans = 0;
    settings   = 1;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset targets: all-black scan keeps the brightest default
    push_entry(6'd0, 6'd0, 6'd0, 1'b1);
    // All-white twice: tie on brightest, darkest default stays
    push_entry(6'd63, 6'd63, 6'd63, 1'b0);
    push_entry(6'd63, 6'd63, 6'd63, 1'b1);
    // Mixed scan with exact target hits and repeated ties
    push_entry(6'd10, 6'd20, 6'd30, 1'b0);
    push_entry(6'd30, 6'd20, 6'd10, 1'b0);
    push_entry(6'd21, 6'd21, 6'd63, 1'b0);
    push_entry(6'd42, 6'd42, 6'd42, 1'b0);
    push_entry(6'd0, 6'd0, 6'd1, 1'b0);
    push_entry(6'd63, 6'd63, 6'd62, 1'b0);
    push_entry(6'd42, 6'd42, 6'd42, 1'b0);
    push_entry(6'd21, 6'd21, 6'd63, 1'b1);

    // Extreme targets so the farthest colors sit exactly at the start distance
    drain_results();
    repeat (4) @(negedge clk_i);
    write_reg(REG_T1_RED, 6'd0);
    write_reg(REG_T1_GREEN, 6'd0);
    write_reg(REG_T1_BLUE, 6'd0);
    write_reg(REG_T2_RED, 6'd63);
    write_reg(REG_T2_GREEN, 6'd63);
    write_reg(REG_T2_BLUE, 6'd63);
    write_reg(CFG_IDX_SPARE_A, 6'd63);
    write_reg(CFG_IDX_SPARE_B, 6'd0);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings++;
    push_entry(6'd63, 6'd63, 6'd63, 1'b0);
    push_entry(6'd0, 6'd0, 6'd0, 1'b0);
    push_entry(6'd63, 6'd63, 6'd63, 1'b0);
    push_entry(6'd0, 6'd0, 6'd0, 1'b1);
    push_entry(6'd63, 6'd63, 6'd63, 1'b1);

    // Random scans under changing targets and flow-control phases
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      repeat (4) @(negedge clk_i);
      for (int i = REG_T1_RED; i <= REG_T2_BLUE; i++) begin
        write_reg(CFG_IDX_W'(i), pick_component());
      end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  pick_component());
      end
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
      settings++;

      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase

      phase_items = 0;
      while (phase_items < 35) begin
        // sometimes let the output side run dry before the next scan
        if ((ph == 1 && phase_items == 0) || $urandom_range(0, 7) == 0) begin
          drain_results();
        end
        // a couple of scans run past the palette size so the index wraps
        if ((ph == 2 || ph == 5) && phase_items == 0) begin
          len = $urandom_range(PALETTE_ENTRIES + 1, PALETTE_ENTRIES + 40);
          long_scans++;
        end else if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(17, 40);
        end else begin
          len = $urandom_range(1, 16);
        end
        for (int k = 0; k < len; k++) begin
          // repeat the previous color now and then to provoke ties
          if (k == 0 || $urandom_range(0, 7) != 0) begin
            r = pick_component();
            g = pick_component();
            b = pick_component();
          end
          push_entry(r, g, b, k == len - 1);
        end
        phase_items += len;
      end
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Scanned %0d palette entries in %0d checked scans, %0d of them past the index wrap,",
             sb.entries_seen, sb.scans_checked, long_scans);
    $display("under %0d target color settings and four flow-control mixes.", settings);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
